[hw/rtl/ndf_pkg.sv]
// Shared types, widths and helpers for the normal displacement falloff pipeline.
// No dependencies; every RTL module of the block imports this package.
package ndf_pkg;

    localparam int MAX_SMOOTH = 16;                     // largest falloff exponent
    localparam int IDX_W      = $clog2(MAX_SMOOTH + 1); // exponent / stage index width
    localparam int SMOOTH_W   = 5;
    localparam int POS_W      = 32;                     // Q16.16 coordinate
    localparam int NRM_W      = 16;                     // Q2.14 normal component
    localparam int DIST_W     = 31;                     // Q15.16 distance
    localparam int INVR_W     = 32;                     // Q8.24 reciprocal radius
    localparam int MOVE_W     = 32;                     // Q16.16 move amount
    localparam int ID_W       = 32;
    localparam int X_W        = 31;                     // Q1.30, 0..1.0
    localparam int X_FRAC     = 30;
    localparam int SCALE_SH   = 10;                     // Q15.16 * Q8.24 -> Q1.30
    localparam int NRM_FRAC   = 14;
    localparam int NP_W       = X_W + IDX_W;            // n * x^k
    localparam int F_W        = NP_W + 2;               // signed falloff sum
    localparam int B_W        = MOVE_W;                 // |f * move| magnitude
    localparam int D_W        = B_W + 1;                // |normal * b| magnitude

    localparam logic [X_W-1:0] ONE_Q30 = X_W'(1) << X_FRAC;

    // Vertex payload; members packed so that id sits in the lowest bits.
    typedef struct packed {
        logic [2:0][NRM_W-1:0] nrm;
        logic [2:0][POS_W-1:0] pos;
        logic [ID_W-1:0]       id;
    } vtx_t;

    // Result payload in bus order: id lowest, then x, y, z.
    typedef struct packed {
        logic [2:0][POS_W-1:0] pos_new;
        logic [ID_W-1:0]       id;
    } res_t;

    // Running powers of x through the power chain.
    typedef struct packed {
        logic [X_W-1:0] x;   // saturated scaled distance
        logic [X_W-1:0] pw;  // x^k at stage k
        logic [X_W-1:0] q;   // x^(n-1) once reached
        logic [X_W-1:0] p;   // x^n once reached
    } pw_t;

    // Settings used by the falloff and amplitude stages.
    typedef struct packed {
        logic              deflate;
        logic [IDX_W-1:0]  n_eff;
        logic [MOVE_W-1:0] move_amount;
    } falloff_cfg_t;

    // Clamp the programmed exponent into 2..MAX_SMOOTH.
    function automatic logic [IDX_W-1:0] eff_n(input logic [SMOOTH_W-1:0] s);
        logic [IDX_W-1:0] r;
        if (s < SMOOTH_W'(2))
            r = IDX_W'(2);
        else if (int'(s) > MAX_SMOOTH)
            r = IDX_W'(MAX_SMOOTH);
        else
            r = IDX_W'(s);
        return r;
    endfunction

endpackage

[hw/rtl/normal_displace_falloff_core.sv]
// Vertex displacement by polynomial brush falloff. One vertex beat is taken per
// clock while the output side takes beats. Each result passes through one
// scaling stage, MAX_SMOOTH - 1 stages of the power chain (one 31x31 multiplier
// each, which sets the depth), three falloff/amplitude stages and two
// displacement stages. Sustained rate is one vertex per cycle whenever the
// output side takes beats; every stage has its own valid bit and fills bubbles
// while a finished result waits on m_tready. Settings are written through the
// cfg_* port and must be left alone while vertices are in flight.
// Depends on ndf_pkg, ndf_scale, ndf_power, ndf_falloff and ndf_displace.
module normal_displace_falloff_core
    import ndf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // settings write port
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    // vertex in
    input  logic          s_tvalid,
    output logic          s_tready,
    // from bit 0: vertex_id[32], position_x[32], position_y[32], position_z[32],
    // normal_x[16], normal_y[16], normal_z[16], distance[31], zero pad[1]
    input  logic [207:0]  s_tdata,
    // displaced vertex out
    output logic          m_tvalid,
    input  logic          m_tready,
    // from bit 0: result_id[32], new_x[32], new_y[32], new_z[32]
    output logic [127:0]  m_tdata
);

    typedef enum logic [1:0] {
        CFG_DEFLATE     = 2'd0,
        CFG_SMOOTHNESS  = 2'd1,
        CFG_INV_RADIUS  = 2'd2,
        CFG_MOVE_AMOUNT = 2'd3
    } cfg_reg_t;

    localparam int SIDE_W = $bits(vtx_t);

    logic                deflate_reg;
    logic [SMOOTH_W-1:0] smooth_reg;
    logic [INVR_W-1:0]   inv_radius_reg;
    logic [MOVE_W-1:0]   move_reg;
    logic [IDX_W-1:0]    n_eff;
    falloff_cfg_t        fo_cfg;

    vtx_t                in_side;
    logic [DIST_W-1:0]   in_distance;

    // power chain links, index k holds x^k
    logic                pw_valid [1:MAX_SMOOTH];
    logic                pw_ready [1:MAX_SMOOTH];
    pw_t                 pw_data  [1:MAX_SMOOTH];
    vtx_t                pw_side  [1:MAX_SMOOTH];

    logic                fo_valid;
    logic                fo_ready;
    logic [B_W-1:0]      fo_bmag;
    logic                fo_bneg;
    vtx_t                fo_side;
    res_t                out_res;

    // ---------------------------------------------------------------
    // Settings: plain write, no read-back.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deflate_reg    <= 1'b0;
            smooth_reg     <= SMOOTH_W'(2);
            inv_radius_reg <= INVR_W'(32'h0100_0000);
            move_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DEFLATE:     deflate_reg    <= cfg_data[0];
                CFG_SMOOTHNESS:  smooth_reg     <= cfg_data[SMOOTH_W-1:0];
                CFG_INV_RADIUS:  inv_radius_reg <= cfg_data[INVR_W-1:0];
                CFG_MOVE_AMOUNT: move_reg       <= cfg_data[MOVE_W-1:0];
            endcase
        end
    end

    // Exponent outside 2..MAX_SMOOTH is pulled to the nearest end.
    assign n_eff = eff_n(smooth_reg);

    assign fo_cfg.deflate     = deflate_reg;
    assign fo_cfg.n_eff       = n_eff;
    assign fo_cfg.move_amount = move_reg;

    // ---------------------------------------------------------------
    // Unpack the input beat.
    // ---------------------------------------------------------------
    assign in_side     = vtx_t'(s_tdata[SIDE_W-1:0]);
    assign in_distance = s_tdata[SIDE_W +: DIST_W];

    // ---------------------------------------------------------------
    // Stage 1: x = saturate(distance * inverse_radius).
    // ---------------------------------------------------------------
    ndf_scale u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .n_eff          (n_eff),
        .inverse_radius (inv_radius_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .distance       (in_distance),
        .in_side        (in_side),
        .out_valid      (pw_valid[1]),
        .out_ready      (pw_ready[1]),
        .out_pw         (pw_data[1]),
        .out_side       (pw_side[1])
    );

    // ---------------------------------------------------------------
    // Power chain: one multiply per stage, grab x^(n-1) and x^n on the way.
    // ---------------------------------------------------------------
    for (genvar k = 2; k <= MAX_SMOOTH; k++)
    begin : g_pow
        ndf_power u_power (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_k   (IDX_W'(k)),
            .n_eff     (n_eff),
            .in_valid  (pw_valid[k-1]),
            .in_ready  (pw_ready[k-1]),
            .in_pw     (pw_data[k-1]),
            .in_side   (pw_side[k-1]),
            .out_valid (pw_valid[k]),
            .out_ready (pw_ready[k]),
            .out_pw    (pw_data[k]),
            .out_side  (pw_side[k])
        );
    end

    // ---------------------------------------------------------------
    // Falloff, clamp and signed amplitude.
    // ---------------------------------------------------------------
    ndf_falloff u_falloff (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (fo_cfg),
        .in_valid  (pw_valid[MAX_SMOOTH]),
        .in_ready  (pw_ready[MAX_SMOOTH]),
        .in_pw     (pw_data[MAX_SMOOTH]),
        .in_side   (pw_side[MAX_SMOOTH]),
        .out_valid (fo_valid),
        .out_ready (fo_ready),
        .out_bmag  (fo_bmag),
        .out_bneg  (fo_bneg),
        .out_side  (fo_side)
    );

    // ---------------------------------------------------------------
    // Move along the normal; the last stage is the output register.
    // ---------------------------------------------------------------
    ndf_displace u_displace (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fo_valid),
        .in_ready  (fo_ready),
        .in_bmag   (fo_bmag),
        .in_bneg   (fo_bneg),
        .in_side   (fo_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res;

`ifndef NO_ASSERTIONS
    // An empty output register lets every stage move, so input is never held off.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_exponent_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_eff >= IDX_W'(2)) && (n_eff <= IDX_W'(MAX_SMOOTH)))
        else $error("effective exponent out of range");
`endif

endmodule

[hw/rtl/ndf_scale.sv]
// First pipeline stage: distance times reciprocal radius, saturated to 1.0 in Q1.30.
// Depends on ndf_pkg.
module ndf_scale
    import ndf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  n_eff,
    input  logic [INVR_W-1:0] inverse_radius,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DIST_W-1:0] distance,
    input  vtx_t              in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output pw_t               out_pw,
    output vtx_t              out_side
);

    localparam int PROD_W = DIST_W + INVR_W;
    localparam int XRAW_W = PROD_W - SCALE_SH;

    logic [PROD_W-1:0] prod;
    logic [XRAW_W-1:0] x_raw;
    logic [X_W-1:0]    x;
    logic              valid_reg;
    pw_t               pw_reg;
    pw_t               pw_next;
    vtx_t              side_reg;

    assign prod  = PROD_W'(distance) * PROD_W'(inverse_radius);
    assign x_raw = prod[PROD_W-1:SCALE_SH];
    assign x     = (x_raw > XRAW_W'(ONE_Q30)) ? ONE_Q30 : x_raw[X_W-1:0];

    always_comb
    begin
        pw_next.x  = x;
        pw_next.pw = x;
        pw_next.q  = (n_eff == IDX_W'(2)) ? x : '0;
        pw_next.p  = '0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pw_reg   <= pw_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_pw    = pw_reg;
    assign out_side  = side_reg;

endmodule

[hw/rtl/ndf_power.sv]
// One link of the power chain: x^k = (x^(k-1) * x) >> 30, capturing x^(n-1) and x^n.
// Depends on ndf_pkg.
module ndf_power
    import ndf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] stage_k,
    input  logic [IDX_W-1:0] n_eff,
    input  logic             in_valid,
    output logic             in_ready,
    input  pw_t              in_pw,
    input  vtx_t             in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output pw_t              out_pw,
    output vtx_t             out_side
);

    localparam int PROD_W = 2 * X_W;

    logic [PROD_W-1:0] prod;
    logic [X_W-1:0]    pw_k;
    logic              valid_reg;
    pw_t               pw_reg;
    pw_t               pw_next;
    vtx_t              side_reg;

    // Both factors stay at or below 1.0, so the shifted product fits in Q1.30.
    assign prod = PROD_W'(in_pw.pw) * PROD_W'(in_pw.x);
    assign pw_k = prod[X_FRAC +: X_W];

    always_comb
    begin
        pw_next.x  = in_pw.x;
        pw_next.pw = pw_k;
        pw_next.q  = (stage_k == n_eff - IDX_W'(1)) ? pw_k : in_pw.q;
        pw_next.p  = (stage_k == n_eff) ? pw_k : in_pw.p;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pw_reg   <= pw_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_pw    = pw_reg;
    assign out_side  = side_reg;

`ifndef NO_ASSERTIONS
    // Powers of a value at most 1.0 never grow past the base.
    a_pow_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (pw_reg.pw <= pw_reg.x))
        else $error("power exceeds its base");
`endif

endmodule

[hw/rtl/ndf_falloff.sv]
// Falloff polynomial (n-1)x^n - n x^(n-1) + 1, clamped, then scaled by the move amount.
// Three register stages; depends on ndf_pkg.
module ndf_falloff
    import ndf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  falloff_cfg_t cfg,
    input  logic         in_valid,
    output logic         in_ready,
    input  pw_t          in_pw,
    input  vtx_t         in_side,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [B_W-1:0] out_bmag,
    output logic         out_bneg,
    output vtx_t         out_side
);

    localparam int BPROD_W = X_W + MOVE_W;

    // stage 1: weighted powers
    logic [NP_W-1:0]    np_next;
    logic [NP_W-1:0]    nq_next;
    logic [NP_W-1:0]    np_reg;
    logic [NP_W-1:0]    nq_reg;
    vtx_t               side1_reg;
    logic               v1_reg;
    logic               rdy1;
    // stage 2: clamped falloff
    logic signed [F_W-1:0] f_sum;
    logic [X_W-1:0]     f_next;
    logic [X_W-1:0]     f_reg;
    vtx_t               side2_reg;
    logic               v2_reg;
    logic               rdy2;
    // stage 3: signed amplitude
    logic [MOVE_W-1:0]  m_abs;
    logic [BPROD_W-1:0] b_prod;
    logic [B_W-1:0]     bmag_reg;
    logic               bneg_reg;
    vtx_t               side3_reg;
    logic               v3_reg;
    logic               rdy3;

    assign np_next = NP_W'(cfg.n_eff - IDX_W'(1)) * NP_W'(in_pw.p);
    assign nq_next = NP_W'(cfg.n_eff) * NP_W'(in_pw.q);

    assign f_sum = $signed({2'b00, np_reg}) - $signed({2'b00, nq_reg})
                 + $signed(F_W'(ONE_Q30));

    always_comb
    begin
        priority if (f_sum[F_W-1])
            f_next = '0;
        else if (f_sum > $signed(F_W'(ONE_Q30)))
            f_next = ONE_Q30;
        else
            f_next = f_sum[X_W-1:0];
    end

    // Magnitude times magnitude truncates toward zero; the sign rides alongside.
    assign m_abs  = cfg.move_amount[MOVE_W-1] ? (~cfg.move_amount + MOVE_W'(1))
                                              : cfg.move_amount;
    assign b_prod = BPROD_W'(f_reg) * BPROD_W'(m_abs);

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            np_reg    <= np_next;
            nq_reg    <= nq_next;
            side1_reg <= in_side;
        end
        if (rdy2 && v1_reg)
        begin
            f_reg     <= f_next;
            side2_reg <= side1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            bmag_reg  <= b_prod[X_FRAC +: B_W];
            bneg_reg  <= cfg.move_amount[MOVE_W-1] ^ cfg.deflate;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_bmag  = bmag_reg;
    assign out_bneg  = bneg_reg;
    assign out_side  = side3_reg;

`ifndef NO_ASSERTIONS
    a_falloff_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (f_reg <= ONE_Q30))
        else $error("falloff outside 0..1.0");

    // With f at most 1.0 the amplitude cannot pass the largest move magnitude.
    a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (bmag_reg <= (B_W'(1) << (MOVE_W - 1))))
        else $error("amplitude magnitude out of range");
`endif

endmodule

[hw/rtl/ndf_displace.sv]
// Per-axis displacement along the normal and saturating add to the position.
// Two register stages; depends on ndf_pkg.
module ndf_displace
    import ndf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [B_W-1:0] in_bmag,
    input  logic           in_bneg,
    input  vtx_t           in_side,
    output logic           out_valid,
    input  logic           out_ready,
    output res_t           out_res
);

    localparam int DPROD_W = NRM_W + B_W;
    localparam int SUM_W   = D_W + 2;
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    logic [2:0][NRM_W-1:0]   n_abs;
    logic [2:0][DPROD_W-1:0] d_prod;
    logic [2:0][D_W-1:0]     dmag_reg;
    logic [2:0]              dneg_reg;
    logic [2:0][POS_W-1:0]   pos1_reg;
    logic [ID_W-1:0]         id1_reg;
    logic                    v1_reg;
    logic                    rdy1;
    logic [2:0][SUM_W-1:0]   d_sig;
    logic [2:0][SUM_W-1:0]   sum;
    res_t                    res_next;
    res_t                    res_reg;
    logic                    v2_reg;
    logic                    rdy2;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            n_abs[a]  = in_side.nrm[a][NRM_W-1] ? (~in_side.nrm[a] + NRM_W'(1))
                                                : in_side.nrm[a];
            d_prod[a] = DPROD_W'(n_abs[a]) * DPROD_W'(in_bmag);
        end
    end

    always_comb
    begin
        res_next.id = id1_reg;
        for (int a = 0; a < 3; a++)
        begin
            d_sig[a] = dneg_reg[a] ? (~SUM_W'(dmag_reg[a]) + SUM_W'(1))
                                   : SUM_W'(dmag_reg[a]);
            sum[a]   = {{(SUM_W-POS_W){pos1_reg[a][POS_W-1]}}, pos1_reg[a]} + d_sig[a];
            // Overflow when the bits above the coordinate disagree with its sign.
            if (sum[a][SUM_W-1:POS_W-1] == '0 || sum[a][SUM_W-1:POS_W-1] == '1)
                res_next.pos_new[a] = sum[a][POS_W-1:0];
            else
                res_next.pos_new[a] = sum[a][SUM_W-1] ? POS_MIN : POS_MAX;
        end
    end

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            for (int a = 0; a < 3; a++)
            begin
                dmag_reg[a] <= d_prod[a][NRM_FRAC +: D_W];
                dneg_reg[a] <= in_side.nrm[a][NRM_W-1] ^ in_bneg;
            end
            pos1_reg <= in_side.pos;
            id1_reg  <= in_side.id;
        end
        if (rdy2 && v1_reg)
            res_reg <= res_next;
    end

    assign out_valid = v2_reg;
    assign out_res   = res_reg;

endmodule

[test/ndf_move_check_pkg.sv]
`timescale 1ns / 1ps
// Bench-side model and scoreboard for the normal displacement falloff core: vertex and
// result records, a settings mirror and a queue of predicted moves.
// Depends on ndf_pkg for the largest falloff exponent.
package ndf_move_check_pkg;
    import ndf_pkg::MAX_SMOOTH;

    typedef enum logic [1:0] {
        REG_DEFLATE,
        REG_SMOOTHNESS,
        REG_INV_RADIUS,
        REG_MOVE_AMOUNT
    } brush_reg_t;

    typedef struct {
        logic [31:0]        id;
        logic signed [31:0] pos [3];   // Q16.16
        logic signed [15:0] nrm [3];   // Q2.14
        logic [30:0]        distance;  // Q15.16
    } vertex_t;

    typedef struct {
        logic [31:0]        id;
        logic signed [31:0] pos [3];
    } moved_vertex_t;

    localparam longint UNIT_Q30 = 64'sd1 << 30;

    // (a * b) >> sh, truncated toward zero
    function automatic longint scale_toward_zero(input longint a, input longint b,
                                                 input int unsigned sh);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mag;
        ma  = (a < 0) ? longint'(-a) : longint'(a);
        mb  = (b < 0) ? longint'(-b) : longint'(b);
        mag = (ma * mb) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    class vertex_move_book;
        logic               deflate     = 1'b0;
        logic [4:0]         smoothness  = 5'd2;
        logic [31:0]        inv_radius  = 32'h0100_0000;
        logic signed [31:0] move_amount = '0;
        moved_vertex_t      due_moves [$];
        int unsigned        faults  = 0;
        int unsigned        checked = 0;

        function void set_register(input brush_reg_t idx, input logic [31:0] val);
            case (idx)
                REG_DEFLATE:     deflate     = val[0];
                REG_SMOOTHNESS:  smoothness  = val[4:0];
                REG_INV_RADIUS:  inv_radius  = val;
                REG_MOVE_AMOUNT: move_amount = val;
                default: ;
            endcase
        endfunction

        function void log_fault(input string msg);
            faults++;
            if (faults <= 10)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // Work out where an accepted vertex should land and queue it.
        function void note_vertex(input vertex_t v);
            longint unsigned x;
            longint unsigned q;
            longint unsigned p;
            longint          f;
            longint          b;
            longint          s;
            int              n;
            moved_vertex_t   m;
            x = (64'(v.distance) * 64'(inv_radius)) >> 10;
            if (x > UNIT_Q30)
                x = UNIT_Q30;
            n = int'(smoothness);
            if (n < 2)
                n = 2;
            if (n > MAX_SMOOTH)
                n = MAX_SMOOTH;
            q = UNIT_Q30;
            for (int k = 0; k < n - 1; k++)
                q = (q * x) >> 30;
            p = (q * x) >> 30;
            f = UNIT_Q30 + longint'(n - 1) * longint'(p) - longint'(n) * longint'(q);
            if (f < 0)
                f = 0;
            if (f > UNIT_Q30)
                f = UNIT_Q30;
            b = scale_toward_zero(f, longint'(move_amount), 30);
            if (deflate)
                b = -b;
            m.id = v.id;
            for (int a = 0; a < 3; a++)
            begin
                s = longint'(v.pos[a]) + scale_toward_zero(longint'(v.nrm[a]), b, 14);
                if (s > 64'sh7FFF_FFFF)
                    s = 64'sh7FFF_FFFF;
                if (s < -64'sh8000_0000)
                    s = -64'sh8000_0000;
                m.pos[a] = 32'(s);
            end
            due_moves.push_back(m);
        endfunction

        function void check_moved(input moved_vertex_t got);
            moved_vertex_t want;
            string         axis_name [3];
            axis_name = '{"new_x", "new_y", "new_z"};
            checked++;
            if (due_moves.size() == 0)
            begin
                log_fault($sformatf("result id %h with nothing outstanding", got.id));
                return;
            end
            want = due_moves.pop_front();
            if (got.id !== want.id)
                log_fault($sformatf("result_id: expected %h, got %h", want.id, got.id));
            for (int a = 0; a < 3; a++)
            begin
                if (got.pos[a] !== want.pos[a])
                    log_fault($sformatf("%s of vertex %h: expected %h, got %h",
                                        axis_name[a], want.id, want.pos[a], got.pos[a]));
            end
        endfunction
    endclass

endpackage

[test/tb.sv]
`timescale 1ns / 1ps
// Top-level bench for normal_displace_falloff_core: streams vertex beats under many brush
// settings and checks every displaced vertex against the predictor.
// Depends on the core RTL, ndf_pkg and ndf_move_check_pkg.
module tb;
    import ndf_move_check_pkg::*;

    localparam int PIPE_DEPTH    = 21;              // vertex beat to result beat
    localparam int SETTLE        = PIPE_DEPTH + 4;  // quiet cycles before a settings change
    localparam int HOLD_OFF      = 80;              // long output stall, well past the depth
    localparam int HOLD_AFTER    = 260;             // results taken before that stall
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 105;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_wr_en = 1'b0;
    brush_reg_t   cfg_index = REG_DEFLATE;
    logic [31:0]  cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    // from bit 0: vertex_id, position_x/y/z, normal_x/y/z, distance, zero pad
    logic [207:0] s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // from bit 0: result_id, new_x, new_y, new_z
    logic [127:0] m_tdata;

    int              idle_pct   = 0;  // chance per cycle of starting an idle burst
    int unsigned     phases_run = 0;
    vertex_move_book book       = new;

    normal_displace_falloff_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run.
    initial
    begin
        #200000;
        $display("normal_displace_falloff_core verification failed");
        $finish;
    end

    // Output side: take result beats, check them, and throttle m_tready.
    // Once HOLD_AFTER results are in, hold off for the HOLD_OFF stall so the
    // pipeline fills and the core has to push back on the vertex stream.
    initial
    begin : result_sink
        int unsigned   stall_left;
        bit            held;
        moved_vertex_t got;
        stall_left = 0;
        held       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.id     = m_tdata[31:0];
                got.pos[0] = m_tdata[63:32];
                got.pos[1] = m_tdata[95:64];
                got.pos[2] = m_tdata[127:96];
                book.check_moved(got);
            end
            if (!held && book.checked >= HOLD_AFTER)
            begin
                held       = 1'b1;
                stall_left = HOLD_OFF;
            end
            // one nonblocking write of m_tready per edge, whichever branch runs
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(0, 2);  // random idle burst starting with this cycle
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one vertex beat, perhaps after a short idle burst, and hold it until taken.
    // tvalid stays high into the next beat: it is only lowered for a gap or a drain.
    task automatic send_vertex(input vertex_t v);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, v.distance, v.nrm[2], v.nrm[1], v.nrm[0],
                     v.pos[2], v.pos[1], v.pos[0], v.id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        book.note_vertex(v);
    endtask

    // Drop tvalid, wait for every queued move to come back, then let the pipe go quiet.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (book.due_moves.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all four brush registers back to back; only called with the pipe empty.
    task automatic program_brush(input logic [31:0] dfl, input logic [31:0] smooth,
                                 input logic [31:0] inv, input logic [31:0] move);
        logic [31:0] word [4];
        word = '{dfl, smooth, inv, move};
        cfg_wr_en <= 1'b1;
        for (int r = 0; r < 4; r++)
        begin
            cfg_index <= brush_reg_t'(r);
            cfg_data  <= word[r];
            @(posedge clk);
            book.set_register(brush_reg_t'(r), word[r]);
        end
        cfg_wr_en <= 1'b0;
        phases_run++;
    endtask

    function automatic vertex_t make_vertex(input logic [31:0] id,
                                            input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] pz,
                                            input logic [15:0] nx, input logic [15:0] ny,
                                            input logic [15:0] nz, input logic [30:0] dist_q16);
        vertex_t v;
        v.id       = id;
        v.pos[0]   = px;
        v.pos[1]   = py;
        v.pos[2]   = pz;
        v.nrm[0]   = nx;
        v.nrm[1]   = ny;
        v.nrm[2]   = nz;
        v.distance = dist_q16;
        return v;
    endfunction

    // Random vertex. Most distances are aimed at the live part of the falloff curve
    // for the current radius; the rest are raw or short. Positions lean towards the
    // rails now and then so that saturation gets exercised.
    function automatic vertex_t random_vertex();
        vertex_t         v;
        int unsigned     pick;
        longint unsigned aim;
        v.id = $urandom();
        for (int a = 0; a < 3; a++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                v.pos[a] = {16'h7FFF, 16'($urandom())};
            else if (pick == 1)
                v.pos[a] = {16'h8000, 16'($urandom())};
            else if (pick < 5)
                v.pos[a] = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
            else
                v.pos[a] = $urandom();
            if ($urandom_range(0, 9) < 7)
                v.nrm[a] = 16'($urandom_range(0, 32768)) - 16'h4000;
            else
                v.nrm[a] = 16'($urandom());
        end
        pick = $urandom_range(0, 9);
        if (pick < 6 && book.inv_radius != 0)
        begin
            aim = 64'($urandom_range(0, 32'h5000_0000)) << 10;
            aim = aim / 64'(book.inv_radius);
            v.distance = (aim > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(aim);
        end
        else if (pick < 8)
            v.distance = 31'($urandom());
        else
            v.distance = 31'($urandom_range(0, 32'h0003_FFFF));
        return v;
    endfunction

    initial
    begin : stimulus
        int unsigned smooth_plan [RANDOM_PHASES];
        int          idle_plan   [RANDOM_PHASES];
        logic [31:0] dfl_w;
        logic [31:0] smooth_w;
        logic [31:0] inv_w;
        logic [31:0] move_w;

        // exponents below two and above the maximum show up here as well
        smooth_plan = '{1, 17, 3, 31, 0, 16, 9, 5};
        // idle bursts vary by phase; the last phase runs flat out
        idle_plan   = '{20, 0, 10, 30, 0, 15, 8, 0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero move amount, so every vertex stays where it is.
        send_vertex(make_vertex(32'h0000_0000, 32'h0, 32'h0, 32'h0,
                                16'h4000, 16'h0, 16'h0, 31'h0));
        send_vertex(make_vertex(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                16'h8000, 16'h7FFF, 16'hFFFF, 31'h7FFF_FFFF));
        send_vertex(make_vertex(32'h1234_5678, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                                16'h2D41, 16'hD2BF, 16'h0, 31'h0000_8000));
        drain_pipeline();

        // Inflate, quadratic falloff, unit radius, +5.0: walk x across 0, 0.5 and 1,
        // hit the normal extremes and push positions into both rails.
        program_brush(32'd0, 32'd2, 32'h0100_0000, 32'h0005_0000);
        send_vertex(make_vertex(32'd1, 32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 31'h0));
        send_vertex(make_vertex(32'd2, 32'h0001_0000, 32'h0, 32'h0,
                                16'h0, 16'h4000, 16'h0, 31'h0000_8000));
        send_vertex(make_vertex(32'd3, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000,
                                31'h0001_0000));
        send_vertex(make_vertex(32'd4, 32'h0, 32'h0, 32'h0, 16'h4000, 16'h4000, 16'h4000,
                                31'h0000_FFFF));
        send_vertex(make_vertex(32'd5, 32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0,
                                31'h7FFF_FFFF));
        send_vertex(make_vertex(32'd6, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h7FFF, 16'hC000,
                                31'h0000_4000));
        send_vertex(make_vertex(32'd7, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h7FFF_FFF0,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 31'h0));
        send_vertex(make_vertex(32'd8, 32'h8000_0010, 32'h8000_0010, 32'h8000_0010,
                                16'h8000, 16'h8000, 16'h8000, 31'h0));
        send_vertex(make_vertex(32'd9, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                16'h8000, 16'h7FFF, 16'h0, 31'h0));
        drain_pipeline();

        // Deflate, exponent above the maximum, zero inverse radius (full move
        // everywhere) and the most negative move amount.
        program_brush(32'd1, 32'd31, 32'h0, 32'h8000_0000);
        send_vertex(make_vertex(32'h0000_000A, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                                16'h8000, 16'h4000, 16'h7FFF, 31'h7FFF_FFFF));
        send_vertex(make_vertex(32'h0000_000B, 32'h0, 32'h0, 32'h0,
                                16'h0, 16'h0, 16'h0, 31'h0001_2345));
        send_vertex(make_vertex(32'h0000_000C, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                16'h7FFF, 16'hC000, 16'h2000, 31'h0));
        drain_pipeline();

        // Exponent below two, largest inverse radius, largest move amount.
        program_brush(32'd0, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(make_vertex(32'h0000_0010, 32'h0, 32'h0, 32'h0,
                                16'h4000, 16'h0, 16'h0, 31'h1));
        send_vertex(make_vertex(32'h0000_0011, 32'h0, 32'h0, 32'h0,
                                16'h4000, 16'h4000, 16'h0, 31'h40));
        send_vertex(make_vertex(32'h0000_0012, 32'h0, 32'h0, 32'h0,
                                16'h4000, 16'h0, 16'h4000, 31'h100));
        send_vertex(make_vertex(32'h0000_0013, 32'h0, 32'h0, 32'h0,
                                16'h7FFF, 16'h8000, 16'h0, 31'h0));
        send_vertex(make_vertex(32'h0000_0014, 32'h0, 32'h0, 32'h0,
                                16'h0, 16'h4000, 16'h0, 31'h80));
        drain_pipeline();

        // Steepest exact exponent with a negative move amount.
        program_brush(32'd0, 32'd16, 32'h0100_0000, 32'hFFFB_0000);
        send_vertex(make_vertex(32'h0000_0020, 32'h0, 32'h0, 32'h0,
                                16'h4000, 16'h0, 16'h0, 31'h0000_8000));
        send_vertex(make_vertex(32'h0000_0021, 32'h0, 32'h0, 32'h0,
                                16'h0, 16'h4000, 16'h0, 31'h0000_C000));
        send_vertex(make_vertex(32'h0000_0022, 32'h0, 32'h0, 32'h0,
                                16'h0, 16'h0, 16'h4000, 31'h0000_2000));

        // Random phases: fresh settings each time, junk in the unused upper bits
        // of the narrow registers, and both modes by alternation.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_pipeline();
            dfl_w         = $urandom();
            dfl_w[0]      = ph[0];
            smooth_w      = $urandom();
            smooth_w[4:0] = (ph == RANDOM_PHASES - 1) ? 5'($urandom()) : 5'(smooth_plan[ph]);
            case (ph)
                0:       inv_w = 32'hFFFF_FFFF;
                1:       inv_w = 32'h0;
                2, 5:    inv_w = 32'h0100_0000 >> $urandom_range(0, 10);
                default: inv_w = $urandom();
            endcase
            case (ph)
                2:         move_w = 32'h7FFF_FFFF;
                5:         move_w = 32'h8000_0000;
                1, 4, 6:   move_w = 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
                default:   move_w = $urandom();
            endcase
            program_brush(dfl_w, smooth_w, inv_w, move_w);
            idle_pct = idle_plan[ph];
            repeat (PHASE_ITEMS) send_vertex(random_vertex());
        end
        drain_pipeline();

        $display("Displaced vertices checked: %0d over %0d brush settings plus reset values,",
                 book.checked, phases_run);
        $display("both modes, clamped exponents, extreme radii and moves, with a long output hold.");
        if (book.faults == 0 && book.due_moves.size() == 0)
            $display("normal_displace_falloff_core verification clean");
        else
        begin
            if (book.due_moves.size() != 0)
                $display("%0d expected results never arrived", book.due_moves.size());
            $display("%0d mismatches in total", book.faults);
            $display("normal_displace_falloff_core verification failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/ndf_pkg.sv
hw/rtl/ndf_scale.sv
hw/rtl/ndf_power.sv
hw/rtl/ndf_falloff.sv
hw/rtl/ndf_displace.sv
hw/rtl/normal_displace_falloff_core.sv
test/ndf_move_check_pkg.sv
test/tb.sv
